FILE: sv/kss_pkg.sv
// Package: word types, register indexes, phase codes and decode tables for the keypad scanner.
`timescale 1ns / 1ps

package kss_pkg;

  localparam int unsigned NumDigits = 8;
  localparam int unsigned DigitSelW = 3;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned TimeoutW  = 20;
  localparam int unsigned CountW    = 20;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 20;

  localparam logic [CfgIdxW-1:0] RegDebounce = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTimeout  = 2'd1;

  localparam logic [DebounceW-1:0] DebounceReset = 16'd10;
  localparam logic [TimeoutW-1:0]  TimeoutReset  = 20'd5000;

  localparam logic [3:0] NoLine = 4'hf;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_RELEASE  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [3:0] row_sense;
    logic [3:0] col_sense;
  } in_word_t;

  typedef struct packed {
    logic [DigitSelW-1:0] digit_select;
    logic [7:0]           segments;
    logic                 key_valid;
    logic [3:0]           key_code;
  } out_word_t;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ticks;
    logic [TimeoutW-1:0]  release_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] code;
  } key_evt_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] idx;
  } line_t;

  // Exactly one line low gives its index; anything else is rejected.
  function automatic line_t one_low_line(input logic [3:0] pat);
    line_t r;
    r = '{ok: 1'b1, idx: 2'd0};
    case (pat)
      4'h7:    r.idx = 2'd0;
      4'hb:    r.idx = 2'd1;
      4'hd:    r.idx = 2'd2;
      4'he:    r.idx = 2'd3;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] seg_pattern(input logic [3:0] code);
    logic [7:0] s;
    case (code)
      4'h0:    s = 8'h3f;
      4'h1:    s = 8'h06;
      4'h2:    s = 8'h5b;
      4'h3:    s = 8'h4f;
      4'h4:    s = 8'h66;
      4'h5:    s = 8'h6d;
      4'h6:    s = 8'h7d;
      4'h7:    s = 8'h07;
      4'h8:    s = 8'h7f;
      4'h9:    s = 8'h6f;
      4'ha:    s = 8'h77;
      4'hb:    s = 8'h7c;
      4'hc:    s = 8'h39;
      4'hd:    s = 8'h5e;
      4'he:    s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/kss_key_fsm.sv
// Key scan state machine: idle, debounce count, release wait and key decode.
`timescale 1ns / 1ps

module kss_key_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kss_pkg::cfg_t     cfg_i,
  input  logic              step_i,
  input  logic [3:0]        row_i,
  input  logic [3:0]        col_i,
  output kss_pkg::key_evt_t key_o
);
  import kss_pkg::*;

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [CountW-1:0]   count_inc;
  logic                deb_done;
  logic                rel_done;
  line_t               row_line, col_line;

  assign count_inc = count_q + CountW'(1);
  // A zero debounce setting acts as one: the incremented count is never zero here.
  assign deb_done  = count_inc >= CountW'(cfg_i.debounce_ticks);
  assign rel_done  = (col_i == NoLine) || (count_q >= CountW'(cfg_i.release_timeout_ticks));
  assign row_line  = one_low_line(row_i);
  assign col_line  = one_low_line(col_i);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    case (phase_q)
      PH_DEBOUNCE: begin
        count_d = count_inc;
        if (deb_done) begin
          count_d = '0;
          phase_d = (row_i == NoLine) ? PH_IDLE : PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        if (rel_done) begin
          phase_d = PH_IDLE;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (row_i != NoLine) begin
          phase_d = PH_DEBOUNCE;
          count_d = '0;
        end
      end
    endcase
  end

  always_comb begin
    key_o = '{valid: 1'b0, code: 4'd0};
    case (phase_q)
      PH_DEBOUNCE: begin
        if (deb_done && row_i != NoLine && row_line.ok && col_line.ok) begin
          key_o.valid = 1'b1;
          key_o.code  = {col_line.idx, row_line.idx};
        end
      end
      default: key_o = '{valid: 1'b0, code: 4'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: sv/keypad_scan_to_seven_segment_shift_core.sv
// Top level: keypad scanner with shifting digit store and multiplexed display output.
//
//   channel  direction  word                                       accepted when
//   in       input      row_sense, col_sense                       in_valid_i & in_ready_o
//   out      output     digit_select, segments, key_valid, code    out_valid_o & out_ready_i
//   cfg      input      cfg_index_i, cfg_data_i                    cfg_valid_i & cfg_ready_o
//
// Each input word yields one output word in the cycle after it is taken; a word can be
// taken every cycle, set by the single output register. in_ready_o stays high while
// that register is empty or is being drained, so the input stalls only when the output
// stalls. Reset clears the phase, the tick counter, the display index and all digits
// to blank, and loads the default debounce and timeout settings. Config is always ready.
`timescale 1ns / 1ps

module keypad_scan_to_seven_segment_shift_core #(
  parameter int unsigned NUM_DIGITS = kss_pkg::NumDigits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  kss_pkg::in_word_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output kss_pkg::out_word_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kss_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [kss_pkg::CfgDataW-1:0]      cfg_data_i
);
  import kss_pkg::*;

  localparam int unsigned IdxW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  cfg_t                 cfg_q;
  key_evt_t             key;
  logic                 step;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [7:0]           store_q [NUM_DIGITS];
  out_word_t            out_q, out_d;
  logic                 out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks        <= DebounceReset;
      cfg_q.release_timeout_ticks <= TimeoutReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDebounce: cfg_q.debounce_ticks        <= cfg_data_i[DebounceW-1:0];
        RegTimeout:  cfg_q.release_timeout_ticks <= cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  kss_key_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .step_i (step),
    .row_i  (in_data_i.row_sense),
    .col_i  (in_data_i.col_sense),
    .key_o  (key)
  );

  assign idx_d = (idx_q == IdxW'(NUM_DIGITS - 1)) ? '0 : idx_q + IdxW'(1);

  // Show the store as it stands before this word's key lands in it.
  always_comb begin
    out_d.digit_select = DigitSelW'(idx_q);
    out_d.segments     = store_q[idx_q];
    out_d.key_valid    = key.valid;
    out_d.key_code     = key.code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (step) begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q[0] <= '0;
    end else if (step && key.valid) begin
      store_q[0] <= seg_pattern(key.code);
    end
  end

  for (genvar g = 1; g < NUM_DIGITS; g++) begin : g_shift
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        store_q[g] <= '0;
      end else if (step && key.valid) begin
        store_q[g] <= store_q[g-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the word until taken.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: tb/tb_keypad_scan_to_seven_segment_shift_core.sv
// Self-checking testbench for the keypad scanner with shifting seven-segment digit store.
`timescale 1ns / 1ps

module tb_keypad_scan_to_seven_segment_shift_core;
  import kss_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;
  localparam int unsigned MaxGap     = 8;
  localparam int unsigned HoldAt     = 400;
  localparam int unsigned HoldCycles = 300;

  // Tracks the block's phase, counter, digit store and display index tick by tick.
  class keypad_scoreboard;
    logic [DebounceW-1:0] debounce;
    logic [TimeoutW-1:0]  timeout;
    phase_e               phase;
    logic [CountW-1:0]    ticks;
    logic [7:0]           digits [NumDigits];
    logic [DigitSelW-1:0] digit_idx;
    logic [7:0]           glyphs [16];
    out_word_t            expected_words [$];
    int unsigned          errors;
    int unsigned          keys;

    function new();
      glyphs = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
                 8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71};
      debounce  = DebounceReset;
      timeout   = TimeoutReset;
      phase     = PH_IDLE;
      ticks     = '0;
      digit_idx = '0;
      errors    = 0;
      keys      = 0;
      foreach (digits[i]) digits[i] = 8'h00;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == RegDebounce) debounce = data[DebounceW-1:0];
      else if (idx == RegTimeout) timeout = data[TimeoutW-1:0];
    endfunction

    function int low_line(logic [3:0] pat);
      case (pat)
        4'h7:    return 0;
        4'hb:    return 1;
        4'hd:    return 2;
        4'he:    return 3;
        default: return -1;
      endcase
    endfunction

    function void take_tick(in_word_t w);
      out_word_t o;
      int        r;
      int        c;
      logic [3:0] code;
      // Display shows the store as it stood before this tick.
      o.digit_select = digit_idx;
      o.segments     = digits[digit_idx];
      o.key_valid    = 1'b0;
      o.key_code     = 4'h0;
      case (phase)
        PH_DEBOUNCE: begin
          ticks = ticks + 1'b1;
          if (ticks >= debounce) begin
            if (w.row_sense == NoLine) begin
              phase = PH_IDLE;
            end else begin
              r = low_line(w.row_sense);
              c = low_line(w.col_sense);
              if (r >= 0 && c >= 0) begin
                code = 4'(r + 4 * c);
                o.key_valid = 1'b1;
                o.key_code  = code;
                for (int i = NumDigits - 1; i > 0; i--) digits[i] = digits[i-1];
                digits[0] = glyphs[code];
                keys++;
              end
              phase = PH_RELEASE;
            end
            ticks = '0;
          end
        end
        PH_RELEASE: begin
          if (w.col_sense == NoLine || ticks >= timeout) begin
            phase = PH_IDLE;
            ticks = '0;
          end else begin
            ticks = ticks + 1'b1;
          end
        end
        default: begin
          phase = PH_IDLE;
          if (w.row_sense != NoLine) begin
            phase = PH_DEBOUNCE;
            ticks = '0;
          end
        end
      endcase
      digit_idx = DigitSelW'((digit_idx + 1) % NumDigits);
      expected_words.push_back(o);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: output word with none expected, expected none, actual %h", $time, got);
        return;
      end
      want = expected_words.pop_front();
      compare_field("digit_select", 8'(want.digit_select), 8'(got.digit_select));
      compare_field("segments", want.segments, got.segments);
      compare_field("key_valid", 8'(want.key_valid), 8'(got.key_valid));
      compare_field("key_code", 8'(want.key_code), 8'(got.key_code));
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_word_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_word_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = RegDebounce;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;

  keypad_scoreboard sb;
  bit               idle_on    = 1'b1;
  int unsigned      deb_eff    = DebounceReset;
  int unsigned      ticks_sent = 0;
  int unsigned      settings   = 0;

  keypad_scan_to_seven_segment_shift_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_word(out_data_o);
      if (in_valid_i && in_ready_o) sb.take_tick(in_data_i);
    end
  end

  // Output side: random stalls per word while idle_on is set, plus one long hold-off to back up the input.
  initial begin : receiver
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = idle_on ? $urandom_range(0, MaxGap) : 0;
      if (taken == HoldAt) gap = HoldCycles;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
      taken++;
    end
  end

  task automatic send_tick(input logic [3:0] row, input logic [3:0] col);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{row_sense: row, col_sense: col};
    @(posedge clk_i);
    while (!(in_valid_i && in_ready_o)) @(posedge clk_i);
    ticks_sent++;
  endtask

  function automatic logic [3:0] single_low();
    case ($urandom_range(0, 3))
      0:       return 4'h7;
      1:       return 4'hb;
      2:       return 4'hd;
      default: return 4'he;
    endcase
  endfunction

  // Hold a press, linger with the columns still down, then release.
  task automatic press(input logic [3:0] row, input logic [3:0] col,
                       input int unsigned hold, input int unsigned linger);
    logic [3:0] lrow;
    lrow = $urandom_range(0, 1) ? row : NoLine;
    repeat (hold) send_tick(row, col);
    repeat (linger) send_tick(lrow, 4'($urandom_range(0, 14)));
    send_tick(NoLine, NoLine);
  endtask

  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o)) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Return the block to idle, drain every expected word, then load new settings.
  task automatic configure(input logic [CfgDataW-1:0] deb, input logic [CfgDataW-1:0] tmo,
                           input bit poke_spare);
    repeat (deb_eff + 2) send_tick(NoLine, NoLine);
    in_valid_i <= 1'b0;
    // Let the monitor log the last word before watching the queue drain.
    @(posedge clk_i);
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (poke_spare) begin
      cfg_put(RegSpare2, CfgDataW'($urandom()));
      cfg_put(RegSpare3, CfgDataW'($urandom()));
    end
    cfg_put(RegDebounce, deb);
    cfg_put(RegTimeout, tmo);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    deb_eff = (deb[DebounceW-1:0] == '0) ? 1 : deb[DebounceW-1:0];
    settings++;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned hold;
    int unsigned kind;
    target = ticks_sent + count;
    while (ticks_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        hold = deb_eff + 1 + $urandom_range(0, 2);
        press(single_low(), single_low(), hold, $urandom_range(0, 6));
      end else if (kind == 6) begin
        repeat ($urandom_range(1, 3)) send_tick(4'($urandom()), 4'($urandom()));
      end else if (kind == 7) begin
        // Let go before the count ends.
        repeat ($urandom_range(1, deb_eff)) send_tick(single_low(), single_low());
        repeat (deb_eff) send_tick(NoLine, NoLine);
      end else if (kind == 8) begin
        press(4'($urandom_range(0, 14)), 4'($urandom()), deb_eff + 1, $urandom_range(0, 4));
      end else begin
        press(4'($urandom()), 4'($urandom()), $urandom_range(1, deb_eff + 3),
              $urandom_range(0, 6));
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one full-length press of the first key.
    send_tick(NoLine, NoLine);
    press(4'h7, 4'h7, 11, 0);

    configure(20'd1, 20'd0, 1'b0);
    press(4'he, 4'he, 2, 0);
    press(4'h7, 4'he, 2, 0);
    press(4'he, 4'h7, 2, 0);
    // Two rows down: no key, still waits for release; zero timeout ends it at once.
    press(4'h3, 4'he, 2, 2);
    // Press gone when the count ends.
    send_tick(4'h7, 4'h7);
    send_tick(NoLine, NoLine);
    press(4'h0, 4'h0, 2, 1);

    configure(20'd0, 20'd2, 1'b0);
    press(4'hb, 4'hd, 2, 3);

    configure(20'd3, 20'd4, 1'b1);
    run_random(220);
    configure(20'd0, 20'd0, 1'b0);
    run_random(220);
    idle_on = 1'b0;
    configure(20'd1, 20'hfffff, 1'b1);
    run_random(220);
    idle_on = 1'b1;
    configure(20'hf0002, 20'd6, 1'b0);
    run_random(220);
    configure(20'd5, 20'd1, 1'b1);
    run_random(220);
    idle_on = 1'b0;
    configure(20'd2, 20'h5a5a5, 1'b0);
    run_random(100);
    idle_on = 1'b1;
    run_random(100);

    // Long debounce, then a release wait that runs into its timeout.
    idle_on = 1'b0;
    configure(20'd100, 20'd150, 1'b0);
    press(4'hd, 4'hb, 101, 160);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d keypad ticks under %0d register settings; %0d keys decoded and shifted in.",
             ticks_sent, settings, sb.keys);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Timeout with %0d words still expected", sb.expected_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: keypad_scan_to_seven_segment_shift_core.f
sv/kss_pkg.sv
sv/kss_key_fsm.sv
sv/keypad_scan_to_seven_segment_shift_core.sv
tb/tb_keypad_scan_to_seven_segment_shift_core.sv
